/* hdl/lks_pkg.sv */
// Package for the layered key sound lookup.
// Types and constants shared by the layer cells, the top level and the checker.
// No dependencies.
package lks_pkg;

    localparam int KEY_W = 18;
    localparam int SID_W = 16;
    localparam int CODE_W = 16;

    localparam logic [1:0] PT_SHORT  = 2'd0;
    localparam logic [1:0] PT_LONG   = 2'd1;
    localparam logic [1:0] PT_REPEAT = 2'd2;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_EVENT  = 1'b1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DUP  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [1:0] CFG_LAYERS  = 2'd0;
    localparam logic [1:0] CFG_SILENT  = 2'd1;
    localparam logic [1:0] CFG_DEFAULT = 2'd2;

    // decision handed down the layer chain
    typedef struct packed {
        logic                    decided;
        logic                    jump;
        logic                    play;
        logic signed [SID_W-1:0] sid;
    } t_token;

    // sequencer controls broadcast to every cell
    typedef struct packed {
        logic clear;
        logic scan;
        logic wr;
    } t_cell_ctl;

endpackage

/* hdl/lks_cell.sv */
// One layer cell: entry store, fill count, scan compare and one chain stage.
// Depends on lks_pkg.
module lks_cell
    import lks_pkg::*;
#(
    parameter int IDX     = 0,
    parameter int ENTRIES = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  t_cell_ctl                         i_ctl,
    input  logic                              i_sel,
    input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] i_addr,
    input  logic [KEY_W-1:0]                  i_key,
    input  logic signed [SID_W-1:0]           i_wr_sound,
    input  logic [3:0]                        i_layers,
    input  logic signed [SID_W-1:0]           i_silent,
    input  logic signed [SID_W-1:0]           i_default,
    input  t_token                            i_tok,
    output t_token                            o_tok,
    output logic                              o_hit,
    output logic                              o_full
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int FW = $clog2(ENTRIES + 1);

    logic [KEY_W-1:0]        r_mem_key   [ENTRIES];
    logic signed [SID_W-1:0] r_mem_sound [ENTRIES];
    logic [KEY_W-1:0]        r_rd_key;
    logic signed [SID_W-1:0] r_rd_sound;
    logic [AW-1:0]           r_rd_idx;
    logic                    r_rd_en;
    logic [FW-1:0]           r_fill;
    logic                    r_hit;
    logic signed [SID_W-1:0] r_hit_sid;
    t_token                  r_tok;
    t_token                  n_tok;
    logic                    wr;
    logic                    match;
    logic                    active;

    assign wr = i_ctl.wr & i_sel;
    assign match = r_rd_en && !r_hit && (FW'(r_rd_idx) < r_fill) && (r_rd_key == i_key);
    assign active = r_hit && !i_tok.decided && (5'(IDX) < {1'b0, i_layers})
                    && (!i_tok.jump || (IDX == 0));

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem_key[r_fill[AW-1:0]]   <= i_key;
            r_mem_sound[r_fill[AW-1:0]] <= i_wr_sound;
        end
        r_rd_key   <= r_mem_key[i_addr];
        r_rd_sound <= r_mem_sound[i_addr];
        r_rd_idx   <= i_addr;
        if (match) begin
            r_hit_sid <= r_rd_sound;
        end
    end

    always_comb begin
        n_tok = i_tok;
        if (active) begin
            if (r_hit_sid == i_silent) begin
                n_tok.decided = 1'b1;
            end else if (r_hit_sid == i_default) begin
                if (IDX == 0) begin
                    n_tok.decided = 1'b1;
                end else begin
                    n_tok.jump = 1'b1;
                end
            end else begin
                n_tok.decided = 1'b1;
                n_tok.play    = 1'b1;
                n_tok.sid     = r_hit_sid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_rd_en <= 1'b0;
            r_hit   <= 1'b0;
            r_tok   <= '0;
        end else begin
            r_rd_en <= i_ctl.scan;
            r_tok   <= n_tok;
            if (wr) begin
                r_fill <= r_fill + 1'b1;
            end
            if (i_ctl.clear) begin
                r_hit <= 1'b0;
            end else if (match) begin
                r_hit <= 1'b1;
            end
        end
    end

    assign o_tok  = r_tok;
    assign o_hit  = r_hit;
    assign o_full = (r_fill == FW'(ENTRIES));

endmodule

/* hdl/layered_key_sound_lookup.sv */
// Top level of the layered key sound lookup: sequencer, registers, layer chain.
// Depends on lks_pkg and lks_cell.
//
// Usage: an item is taken at a rising edge with i_start high and o_busy low.
// i_kind selects an insert (entry into layer i_layer) or a key event lookup.
// Every item gives one result, shown for one cycle with o_done high; the
// receiver cannot stall it.
// All layer cells scan their stores together, one entry a cycle, in S_SCAN;
// S_DRAIN then waits out the registered store read. An insert then goes to
// S_FINISH; a lookup lets the decision walk down the chain
// of LAYERS cells, one cell a cycle, in S_DECIDE before the result is taken.
// A new item may be accepted in the cycle that o_done is shown.
// Configuration (i_cfg_we, i_cfg_idx, i_cfg_data) must be written while idle;
// the block itself does not enforce it.
// Reset empties every layer, clears the repeat history and loads
// layers_in_use 0, silent id 0, default id 1. No clearing pass is needed.
module layered_key_sound_lookup
    import lks_pkg::*;
#(
    parameter int LAYERS            = 8,
    parameter int ENTRIES_PER_LAYER = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    output logic                    o_busy,
    input  logic                    i_kind,
    input  logic [2:0]              i_layer,
    input  logic [15:0]             i_key_code,
    input  logic [1:0]              i_press_type,
    input  logic signed [15:0]      i_entry_sound,
    input  logic                    i_is_repeat,
    output logic                    o_done,
    output logic                    o_play,
    output logic signed [15:0]      o_sound_id,
    output logic [1:0]              o_insert_status,
    input  logic                    i_cfg_we,
    input  logic [1:0]              i_cfg_idx,
    input  logic [15:0]             i_cfg_data
);

    localparam int AW = (ENTRIES_PER_LAYER > 1) ? $clog2(ENTRIES_PER_LAYER) : 1;
    localparam int DW = (LAYERS > 1) ? $clog2(LAYERS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DECIDE,
        S_FINISH
    } t_state;

    t_state                  r_state;
    logic [AW-1:0]           r_addr;
    logic [DW-1:0]           r_dcnt;
    logic                    r_kind;
    logic [2:0]              r_layer;
    logic [KEY_W-1:0]        r_key;
    logic signed [SID_W-1:0] r_sound;
    logic                    r_prev_rep;
    logic                    r_done;
    logic                    r_play;
    logic signed [SID_W-1:0] r_sid;
    logic [1:0]              r_status;
    logic [3:0]              r_layers_in_use;
    logic signed [SID_W-1:0] r_silent;
    logic signed [SID_W-1:0] r_default;

    t_token                  tok [LAYERS+1];
    logic [LAYERS-1:0]       hits;
    logic [LAYERS-1:0]       fulls;
    logic [LAYERS-1:0]       sel;
    t_cell_ctl               ctl;
    logic                    accept;
    logic                    layer_ok;
    logic                    dup;
    logic                    full;
    logic                    ins_ok;
    logic [1:0]              ev_pt;

    assign accept   = i_start && (r_state == S_IDLE);
    assign layer_ok = (5'(r_layer) < 5'(LAYERS));
    assign dup      = |(hits & sel);
    assign full     = |(fulls & sel);
    assign ins_ok   = (r_kind == KIND_INSERT) && layer_ok && !dup && !full;
    assign ev_pt    = !i_is_repeat ? PT_SHORT : (r_prev_rep ? PT_REPEAT : PT_LONG);

    assign ctl.clear = accept;
    assign ctl.scan  = (r_state == S_SCAN);
    assign ctl.wr    = (r_state == S_FINISH) && ins_ok;

    assign tok[LAYERS] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < LAYERS; gi++) begin : g_cell
            assign sel[gi] = (5'(r_layer) == 5'(gi));
            lks_cell #(
                .IDX     (gi),
                .ENTRIES (ENTRIES_PER_LAYER)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (ctl),
                .i_sel      (sel[gi]),
                .i_addr     (r_addr),
                .i_key      (r_key),
                .i_wr_sound (r_sound),
                .i_layers   (r_layers_in_use),
                .i_silent   (r_silent),
                .i_default  (r_default),
                .i_tok      (tok[gi+1]),
                .o_tok      (tok[gi]),
                .o_hit      (hits[gi]),
                .o_full     (fulls[gi])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layers_in_use <= '0;
            r_silent        <= '0;
            r_default       <= 16'sd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LAYERS:  r_layers_in_use <= i_cfg_data[3:0];
                CFG_SILENT:  r_silent        <= i_cfg_data;
                CFG_DEFAULT: r_default       <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_addr     <= '0;
            r_dcnt     <= '0;
            r_prev_rep <= 1'b0;
            r_done     <= 1'b0;
            r_play     <= 1'b0;
            r_sid      <= '0;
            r_status   <= ST_OK;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_kind  <= i_kind;
                        r_layer <= i_layer;
                        r_sound <= i_entry_sound;
                        r_addr  <= '0;
                        r_dcnt  <= '0;
                        r_state <= S_SCAN;
                        if (i_kind == KIND_EVENT) begin
                            r_key      <= {ev_pt, i_key_code};
                            r_prev_rep <= i_is_repeat;
                        end else begin
                            r_key <= {i_press_type, i_key_code};
                        end
                    end
                end
                S_SCAN: begin
                    if (r_addr == AW'(ENTRIES_PER_LAYER - 1)) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_DRAIN: begin
                    r_state <= (r_kind == KIND_EVENT) ? S_DECIDE : S_FINISH;
                end
                S_DECIDE: begin
                    if (r_dcnt == DW'(LAYERS - 1)) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_dcnt <= r_dcnt + 1'b1;
                    end
                end
                S_FINISH: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                    if (r_kind == KIND_EVENT) begin
                        r_play   <= tok[0].play;
                        r_sid    <= tok[0].play ? tok[0].sid : '0;
                        r_status <= ST_OK;
                    end else begin
                        r_play <= 1'b0;
                        r_sid  <= '0;
                        priority if (!layer_ok) begin
                            r_status <= ST_FULL;
                        end else if (dup) begin
                            r_status <= ST_DUP;
                        end else if (full) begin
                            r_status <= ST_FULL;
                        end else begin
                            r_status <= ST_OK;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy          = (r_state != S_IDLE);
    assign o_done          = r_done;
    assign o_play          = r_play;
    assign o_sound_id      = r_sid;
    assign o_insert_status = r_status;

endmodule

/* hdl/lks_checker.sv */
// Port-level checks for the layered key sound lookup, bound to the top level.
// Depends on lks_pkg and layered_key_sound_lookup.
module lks_checker
    import lks_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_start,
    input logic               o_busy,
    input logic               o_done,
    input logic               o_play,
    input logic signed [15:0] o_sound_id,
    input logic [1:0]         o_insert_status
);

    a_play_no_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_play |-> o_insert_status == ST_OK)
        else $error("played item carries an insert status");

    a_silent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_play |-> o_sound_id == 16'sd0)
        else $error("sound id not zero without play");

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy |=> o_busy && !o_done)
        else $error("accepted item did not start work");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(o_busy) && !o_busy)
        else $error("result without work in progress");

endmodule

bind layered_key_sound_lookup lks_checker u_lks_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_start         (i_start),
    .o_busy          (o_busy),
    .o_done          (o_done),
    .o_play          (o_play),
    .o_sound_id      (o_sound_id),
    .o_insert_status (o_insert_status)
);

/* tb/layered_key_sound_lookup_tb.sv */
// Testbench for layered_key_sound_lookup: a directed table followed by random phases,
// every result checked in order against the table's expected value or a behavioural lookup of the layered tables.
// Depends on lks_pkg and the layered_key_sound_lookup RTL.
module layered_key_sound_lookup_tb;
    import lks_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LAYERS      = 8;
    localparam int ENTRIES     = 32;
    localparam int DIR_ROWS    = 29;
    localparam int PHASES      = 9;
    localparam int PHASE_ITEMS = 136;
    localparam int SETTLE      = 60;
    localparam int MAX_GAP     = 60;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_op;

    typedef struct packed {
        logic                    kind;
        logic [2:0]              layer;
        logic [15:0]             code;
        logic [1:0]              ptype;
        logic signed [15:0]      sound;
        logic                    rep;
    } t_key_item;

    typedef struct packed {
        logic                    play;
        logic signed [15:0]      sid;
        logic [1:0]              status;
    } t_sound_result;

    typedef struct packed {
        t_row_op                 op;
        t_key_item               item;
        logic [1:0]              cfg_idx;
        logic [15:0]             cfg_data;
        logic                    typed;
        t_sound_result           want;
    } t_step_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_start;
    logic               o_busy;
    logic               i_kind;
    logic [2:0]         i_layer;
    logic [15:0]        i_key_code;
    logic [1:0]         i_press_type;
    logic signed [15:0] i_entry_sound;
    logic               i_is_repeat;
    logic               o_done;
    logic               o_play;
    logic signed [15:0] o_sound_id;
    logic [1:0]         o_insert_status;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_idx;
    logic [15:0]        i_cfg_data;

    // shadow copy of the layer stores and registers
    logic [17:0]        shadow_key   [LAYERS][ENTRIES];
    logic signed [15:0] shadow_sound [LAYERS][ENTRIES];
    int                 shadow_fill  [LAYERS];
    logic               prev_repeat;
    logic [3:0]         cfg_layers;
    logic signed [15:0] cfg_silent;
    logic signed [15:0] cfg_default;

    t_sound_result      pending_sounds[$];
    t_sound_result      head;
    int                 mismatch_count = 0;
    logic [15:0]        code_pool [12];
    t_step_row          directed [DIR_ROWS];

    layered_key_sound_lookup #(
        .LAYERS           (LAYERS),
        .ENTRIES_PER_LAYER(ENTRIES)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_kind         (i_kind),
        .i_layer        (i_layer),
        .i_key_code     (i_key_code),
        .i_press_type   (i_press_type),
        .i_entry_sound  (i_entry_sound),
        .i_is_repeat    (i_is_repeat),
        .o_done         (o_done),
        .o_play         (o_play),
        .o_sound_id     (o_sound_id),
        .o_insert_status(o_insert_status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic bit find_entry(input int lay, input logic [17:0] key,
                                      output logic signed [15:0] sid);
        sid = '0;
        for (int i = 0; i < shadow_fill[lay]; i++) begin
            if (shadow_key[lay][i] == key) begin
                sid = shadow_sound[lay][i];
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic t_sound_result predict_sound(input t_key_item it);
        t_sound_result      r;
        logic [17:0]        key;
        logic [1:0]         pt;
        logic signed [15:0] sid;
        int                 idx;
        r = '0;
        if (it.kind == KIND_INSERT) begin
            key = {it.ptype, it.code};
            if (find_entry(it.layer, key, sid)) begin
                r.status = ST_DUP;
            end else if (shadow_fill[it.layer] >= ENTRIES) begin
                r.status = ST_FULL;
            end else begin
                shadow_key[it.layer][shadow_fill[it.layer]]   = key;
                shadow_sound[it.layer][shadow_fill[it.layer]] = it.sound;
                shadow_fill[it.layer]++;
            end
            return r;
        end
        pt = !it.rep ? PT_SHORT : (!prev_repeat ? PT_LONG : PT_REPEAT);
        prev_repeat = it.rep;
        key = {pt, it.code};
        idx = (cfg_layers > LAYERS) ? LAYERS : int'(cfg_layers);
        while (idx > 0) begin
            idx--;
            if (!find_entry(idx, key, sid))
                continue;
            if (sid == cfg_silent)
                return r;
            if (sid == cfg_default) begin
                // jump to the bottom layer; a default there is silence
                if (idx == 0)
                    return r;
                idx = 1;
                continue;
            end
            r.play = 1'b1;
            r.sid  = sid;
            return r;
        end
        return r;
    endfunction

    function automatic t_step_row entry_row(input logic [2:0] layer, input logic [15:0] code,
                                            input logic [1:0] pt, input logic signed [15:0] snd,
                                            input logic typed, input logic [1:0] status);
        t_step_row r;
        r      = '0;
        r.op   = ROW_ITEM;
        r.item = '{KIND_INSERT, layer, code, pt, snd, 1'b0};
        r.typed = typed;
        r.want = '{1'b0, 16'sd0, status};
        return r;
    endfunction

    function automatic t_step_row event_row(input logic [15:0] code, input logic rep,
                                            input logic typed, input logic play,
                                            input logic signed [15:0] sid);
        t_step_row r;
        r      = '0;
        r.op   = ROW_ITEM;
        r.item = '{KIND_EVENT, 3'd0, code, PT_SHORT, 16'sd0, rep};
        r.typed = typed;
        r.want = '{play, sid, ST_OK};
        return r;
    endfunction

    function automatic t_step_row reg_row(input logic [1:0] idx, input logic [15:0] data);
        t_step_row r;
        r          = '0;
        r.op       = ROW_CFG;
        r.cfg_idx  = idx;
        r.cfg_data = data;
        return r;
    endfunction

    function automatic logic signed [15:0] pick_sound();
        case ($urandom_range(0, 9))
            6: return -16'sd1;
            7: return 16'sh7FFF;
            8: return 16'sh8000;
            9: return 16'($urandom);
            default: return 16'($urandom_range(0, 7));
        endcase
    endfunction

    function automatic t_key_item random_item();
        t_key_item it;
        it.kind  = ($urandom_range(0, 99) < 35) ? KIND_INSERT : KIND_EVENT;
        it.layer = 3'($urandom_range(0, 7));
        it.code  = ($urandom_range(0, 9) < 8) ? code_pool[$urandom_range(0, 11)]
                                              : 16'($urandom_range(0, 65535));
        it.ptype = 2'($urandom_range(0, 3));
        it.sound = pick_sound();
        it.rep   = 1'($urandom_range(0, 1));
        return it;
    endfunction

    task automatic flag_mismatch(input string what, input logic signed [31:0] got,
                                 input logic signed [31:0] want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            if (pending_sounds.size() == 0) begin
                flag_mismatch("result with no item pending", o_sound_id, 0);
            end else begin
                head = pending_sounds.pop_front();
                if (o_play !== head.play)
                    flag_mismatch("play", o_play, head.play);
                if (o_sound_id !== head.sid)
                    flag_mismatch("sound_id", o_sound_id, head.sid);
                if (o_insert_status !== head.status)
                    flag_mismatch("insert_status", o_insert_status, head.status);
            end
        end
    end

    task automatic drain();
        i_start <= 1'b0;
        do @(posedge i_clk); while (pending_sounds.size() != 0 || o_busy !== 1'b0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_LAYERS:  cfg_layers  = data[3:0];
            CFG_SILENT:  cfg_silent  = data;
            CFG_DEFAULT: cfg_default = data;
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_item(input t_key_item it, input logic typed,
                             input t_sound_result want, input int idle_pct);
        t_sound_result guess;
        if ($urandom_range(0, 99) < idle_pct) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, MAX_GAP)) @(posedge i_clk);
        end
        i_start       <= 1'b1;
        i_kind        <= it.kind;
        i_layer       <= it.layer;
        i_key_code    <= it.code;
        i_press_type  <= it.ptype;
        i_entry_sound <= it.sound;
        i_is_repeat   <= it.rep;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        guess = predict_sound(it);
        pending_sounds.push_back(typed ? want : guess);
    endtask

    task automatic set_phase(input int p);
        logic [3:0]  lay;
        logic [15:0] sil;
        logic [15:0] dfl;
        case (p)
            0: begin lay = 4'd8;  sil = 16'd0;    dfl = 16'd1;    end
            1: begin lay = 4'd3;  sil = 16'd2;    dfl = 16'd3;    end
            2: begin lay = 4'd15; sil = 16'h8000; dfl = 16'h7FFF; end
            3: begin lay = 4'd1;  sil = 16'd4;    dfl = 16'd4;    end
            4: begin lay = 4'd8;  sil = 16'h7FFF; dfl = 16'h8000; end
            5: begin lay = 4'd6;  sil = 16'd5;    dfl = 16'd0;    end
            6: begin lay = 4'd0;  sil = 16'd1;    dfl = 16'd2;    end
            7: begin lay = 4'd8;  sil = 16'd7;    dfl = 16'd6;    end
            default: begin lay = 4'd5; sil = 16'hFFFF; dfl = 16'd1; end
        endcase
        write_reg(CFG_LAYERS, 16'(lay));
        write_reg(CFG_SILENT, sil);
        write_reg(CFG_DEFAULT, dfl);
    endtask

    initial begin
        int idle;
        i_rst_n       <= 1'b0;
        i_start       <= 1'b0;
        i_kind        <= KIND_INSERT;
        i_layer       <= '0;
        i_key_code    <= '0;
        i_press_type  <= PT_SHORT;
        i_entry_sound <= '0;
        i_is_repeat   <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_LAYERS;
        i_cfg_data    <= '0;

        for (int l = 0; l < LAYERS; l++)
            shadow_fill[l] = 0;
        prev_repeat = 1'b0;
        cfg_layers  = 4'd0;
        cfg_silent  = 16'sd0;
        cfg_default = 16'sd1;

        code_pool[0] = 16'h0000;
        code_pool[1] = 16'hFFFF;
        for (int i = 2; i < 12; i++)
            code_pool[i] = 16'($urandom_range(0, 65535));

        directed = '{
            event_row(16'h0000, 1'b0, 1'b1, 1'b0, 16'sd0),              // nothing in use
            entry_row(3'd0, 16'h0000, PT_SHORT, 16'sd100, 1'b1, ST_OK),
            entry_row(3'd0, 16'h0000, PT_SHORT, 16'sd5, 1'b1, ST_DUP),
            entry_row(3'd7, 16'hFFFF, PT_REPEAT, 16'sh8000, 1'b1, ST_OK),
            entry_row(3'd7, 16'hFFFF, 2'd3, 16'sh7FFF, 1'b1, ST_OK),     // never looked up
            entry_row(3'd3, 16'h1234, PT_LONG, 16'sd0, 1'b0, ST_OK),
            entry_row(3'd5, 16'h1234, PT_LONG, 16'sd1, 1'b0, ST_OK),
            entry_row(3'd0, 16'h1234, PT_LONG, 16'sd77, 1'b0, ST_OK),
            entry_row(3'd0, 16'h00AA, PT_SHORT, 16'sd1, 1'b0, ST_OK),
            entry_row(3'd4, 16'h00AA, PT_SHORT, 16'sd1, 1'b0, ST_OK),
            event_row(16'h0000, 1'b0, 1'b1, 1'b0, 16'sd0),
            reg_row(CFG_LAYERS, 16'd8),
            event_row(16'h0000, 1'b0, 1'b1, 1'b1, 16'sd100),
            event_row(16'hFFFF, 1'b1, 1'b0, 1'b0, 16'sd0),               // long press
            event_row(16'hFFFF, 1'b1, 1'b1, 1'b1, 16'sh8000),            // repeat press
            entry_row(3'd2, 16'hFFFF, PT_LONG, 16'sd9, 1'b0, ST_OK),     // keeps repeat history
            event_row(16'hFFFF, 1'b1, 1'b0, 1'b0, 16'sd0),
            event_row(16'h1234, 1'b0, 1'b0, 1'b0, 16'sd0),
            event_row(16'h1234, 1'b1, 1'b0, 1'b0, 16'sd0),               // jump past silent
            event_row(16'h00AA, 1'b0, 1'b0, 1'b0, 16'sd0),               // default at bottom
            reg_row(CFG_DEFAULT, 16'd0),
            event_row(16'h1234, 1'b1, 1'b0, 1'b0, 16'sd0),
            reg_row(CFG_LAYERS, 16'd15),
            reg_row(CFG_UNUSED, 16'hFFFF),
            event_row(16'h1234, 1'b0, 1'b0, 1'b0, 16'sd0),
            event_row(16'h1234, 1'b1, 1'b0, 1'b0, 16'sd0),
            reg_row(CFG_LAYERS, 16'd4),
            event_row(16'h1234, 1'b0, 1'b0, 1'b0, 16'sd0),
            event_row(16'h1234, 1'b1, 1'b0, 1'b0, 16'sd0)                // silent equals default
        };

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            if (directed[r].op == ROW_CFG)
                write_reg(directed[r].cfg_idx, directed[r].cfg_data);
            else
                send_item(directed[r].item, directed[r].typed, directed[r].want, 0);
        end

        for (int p = 0; p < PHASES; p++) begin
            idle = (p < 3) ? 28 : (p < 6) ? 79 : 0;
            set_phase(p);
            repeat (PHASE_ITEMS)
                send_item(random_item(), 1'b0, '0, idle);
        end

        drain();
        repeat (SETTLE) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
